// ----- src/smc_pkg.sv -----
// ----------------------------------------------------------------------------
// smc_pkg: shared types and constants of the stack machine core
// Status codes, opcodes, sequencer states, memory request type and a sign-extension helper.
// ----------------------------------------------------------------------------
package smc_pkg;

    localparam int unsigned MEM_WORDS_DEF = 65536;
    localparam int unsigned NUM_TRAPS_DEF = 5;

    localparam logic [15:0] BASE_RST  = 16'h0000;
    localparam logic [15:0] TOP_RST   = 16'hFFFF;
    localparam logic [15:0] START_RST = 16'h0010;
    localparam logic [11:0] EXIT_TRAP = 12'd2;

    localparam logic [1:0] REG_BASE  = 2'd0;
    localparam logic [1:0] REG_TOP   = 2'd1;
    localparam logic [1:0] REG_START = 2'd2;

    typedef enum logic [3:0] {
        ST_OK      = 4'd0,
        ST_HALT    = 4'd1,
        ST_TRAP    = 4'd2,
        ST_EXIT    = 4'd3,
        ST_BADOP   = 4'd4,
        ST_BADFUNC = 4'd5,
        ST_UNDER   = 4'd6,
        ST_OVER    = 4'd7,
        ST_DIV0    = 4'd8,
        ST_BADTRAP = 4'd9,
        ST_STOPPED = 4'd10
    } t_status;

    typedef enum logic [3:0] {
        OP_ALU   = 4'd1,
        OP_STACK = 4'd2,
        OP_BR    = 4'd3,
        OP_LDI   = 4'd4,
        OP_LOAD  = 4'd5,
        OP_STW   = 4'd6,
        OP_JMP   = 4'd7,
        OP_JAL   = 4'd8,
        OP_RET   = 4'd9,
        OP_TRAP  = 4'd10,
        OP_HALT  = 4'd11
    } t_opcode;

    localparam logic [11:0] ALU_ADD = 12'd0;
    localparam logic [11:0] ALU_SUB = 12'd1;
    localparam logic [11:0] ALU_MUL = 12'd2;
    localparam logic [11:0] ALU_DIV = 12'd3;
    localparam logic [11:0] ALU_NEG = 12'd4;
    localparam logic [11:0] ALU_INC = 12'd5;
    localparam logic [11:0] ALU_DEC = 12'd6;
    localparam logic [11:0] ALU_ABS = 12'd7;
    localparam logic [11:0] ALU_NOT = 12'd8;
    localparam logic [11:0] ALU_AND = 12'd9;
    localparam logic [11:0] ALU_OR  = 12'd10;
    localparam logic [11:0] ALU_XOR = 12'd11;
    localparam logic [11:0] ALU_SHL = 12'd12;
    localparam logic [11:0] ALU_SHR = 12'd13;

    localparam logic [11:0] SK_SWAP = 12'd0;
    localparam logic [11:0] SK_DUP  = 12'd1;
    localparam logic [11:0] SK_DROP = 12'd2;
    localparam logic [11:0] SK_OVER = 12'd3;

    localparam logic [11:0] BR_EQ  = 12'd0;
    localparam logic [11:0] BR_NE  = 12'd1;
    localparam logic [11:0] BR_Z   = 12'd2;
    localparam logic [11:0] BR_NZ  = 12'd3;
    localparam logic [11:0] BR_N   = 12'd4;
    localparam logic [11:0] BR_P   = 12'd5;

    typedef enum logic [3:0] {
        S_IDLE, S_FETCH, S_R0, S_R1, S_R2, S_R3, S_EXEC, S_DIV,
        S_W1, S_W2, S_TOS, S_TOSC, S_OUT
    } t_state;

    typedef struct packed {
        logic        we;
        logic [15:0] addr;
        logic [15:0] wdata;
    } t_mem_req;

    function automatic logic [15:0] sext12(input logic [11:0] v);
        return {{4{v[11]}}, v};
    endfunction

endpackage

// ----- src/smc_mem.sv -----
// ----------------------------------------------------------------------------
// smc_mem: single-port word memory
// One read or one write per cycle; read data is registered.
// ----------------------------------------------------------------------------
module smc_mem #(
    parameter int unsigned MEM_WORDS = smc_pkg::MEM_WORDS_DEF
) (
    input  logic              i_clk,
    input  smc_pkg::t_mem_req i_req,
    output logic [15:0]       o_rdata
);
    import smc_pkg::*;

    localparam int unsigned AW = $clog2(MEM_WORDS);

    logic [15:0] r_mem [MEM_WORDS];
    logic [AW-1:0] idx;

    assign idx = i_req.addr[AW-1:0];

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[idx] <= i_req.wdata;
        end
        o_rdata <= r_mem[idx];
    end

endmodule

// ----- src/smc_div.sv -----
// ----------------------------------------------------------------------------
// smc_div: unsigned restoring divider
// One quotient bit per cycle while busy, sixteen quotient bits per division.
// ----------------------------------------------------------------------------
module smc_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [15:0] i_num,
    input  logic [15:0] i_den,
    output logic        o_done,
    output logic [15:0] o_quo,
    output logic [15:0] o_rem
);
    import smc_pkg::*;

    logic [4:0]  r_cnt;
    logic        r_busy;
    logic        r_done;
    logic [15:0] r_quo;
    logic [15:0] r_rem;
    logic [15:0] r_den;
    logic [16:0] sh;
    logic [16:0] diff;

    assign sh   = {r_rem, r_quo[15]};
    assign diff = sh - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 5'd16;
                r_quo  <= i_num;
                r_rem  <= '0;
                r_den  <= i_den;
            end else if (r_busy) begin
                if (!diff[16]) begin
                    r_rem <= diff[15:0];
                    r_quo <= {r_quo[14:0], 1'b1};
                end else begin
                    r_rem <= sh[15:0];
                    r_quo <= {r_quo[14:0], 1'b0};
                end
                r_cnt <= r_cnt - 5'd1;
                if (r_cnt == 5'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;
    assign o_rem  = r_rem;

endmodule

// ----- src/stack_machine_core.sv -----
// ----------------------------------------------------------------------------
// stack_machine_core: 16-bit stack CPU around one single-port word memory
// A preload or a stopped execute goes on to the top-of-stack read; an instruction
// passes fetch, three stack reads, operand read, execute, two write slots and the
// top-of-stack read, with the divider's run after execute for a division. One item
// at a time: a new item is taken only after the last result has been taken.
// Synchronous active-low reset restores registers, PC, SP, link and run state;
// memory contents are not cleared.
// ----------------------------------------------------------------------------
module stack_machine_core #(
    parameter int unsigned MEM_WORDS = smc_pkg::MEM_WORDS_DEF,
    parameter int unsigned NUM_TRAPS = smc_pkg::NUM_TRAPS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_func,
    input  logic [15:0] i_load_addr,
    input  logic [15:0] i_load_data,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [3:0]  o_status,
    output logic [15:0] o_instr_pc,
    output logic [15:0] o_next_pc,
    output logic [15:0] o_top_of_stack,
    output logic [15:0] o_stack_ptr,
    output logic [11:0] o_trap_code,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import smc_pkg::*;

    t_state      r_state, n_state;
    t_status     r_status, n_status;
    logic [15:0] r_pc, n_pc, r_sp, n_sp, r_lr, n_lr, r_ipc, n_ipc;
    logic [15:0] r_base, n_base, r_top, n_top, r_start, n_start;
    logic [15:0] r_ins, n_ins, r_t, n_t, r_n, n_n, r_b, n_b, r_tos, n_tos;
    logic [11:0] r_code, n_code;
    logic        r_stopped, n_stopped;
    t_mem_req    r_w1, n_w1, r_w2, n_w2;
    t_mem_req    mem_req;
    logic [15:0] rdata;

    logic        div_start, div_done;
    logic [15:0] div_num, div_den, div_quo, div_rem;

    // execute stage
    logic [3:0]  op;
    logic [11:0] arg;
    logic [15:0] sarg;
    t_status     e_status;
    logic [15:0] e_sp, e_pc, e_lr;
    t_mem_req    e_w1, e_w2;
    logic        e_div;
    logic [16:0] sp17;
    logic [16:0] top17;
    logic        und1, und2, und3;
    logic [15:0] alu_r;
    logic [31:0] prod;
    logic [3:0]  shamt;
    logic        big;
    logic        take;
    logic        cfg_we;
    logic [15:0] q_s, r_s;

    smc_mem #(.MEM_WORDS(MEM_WORDS)) u_mem (
        .i_clk   (i_clk),
        .i_req   (mem_req),
        .o_rdata (rdata)
    );

    smc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quo   (div_quo),
        .o_rem   (div_rem)
    );

    assign op    = r_ins[15:12];
    assign arg   = r_ins[11:0];
    assign sarg  = sext12(arg);
    assign sp17  = {1'b0, r_sp};
    assign top17 = {1'b0, r_top};
    assign und1  = (sp17 + 17'd1) > top17;
    assign und2  = (sp17 + 17'd2) > top17;
    assign und3  = (sp17 + 17'd3) > top17;
    assign prod  = r_n * r_t;
    assign shamt = r_t[3:0];
    assign big   = |r_t[15:4];
    assign div_num = r_n[15] ? 16'(-r_n) : r_n;
    assign div_den = r_t[15] ? 16'(-r_t) : r_t;
    assign q_s = (r_n[15] ^ r_t[15]) ? 16'(-div_quo) : div_quo;
    assign r_s = r_n[15] ? 16'(-div_rem) : div_rem;

    always_comb begin
        alu_r = '0;
        case (arg)
            ALU_ADD: alu_r = r_n + r_t;
            ALU_SUB: alu_r = r_n - r_t;
            ALU_MUL: alu_r = prod[15:0];
            ALU_NEG: alu_r = 16'(-r_t);
            ALU_INC: alu_r = r_t + 16'd1;
            ALU_DEC: alu_r = r_t - 16'd1;
            ALU_ABS: alu_r = r_t[15] ? 16'(-r_t) : r_t;
            ALU_NOT: alu_r = (r_t == 16'd0) ? 16'd1 : 16'd0;
            ALU_AND: alu_r = r_n & r_t;
            ALU_OR:  alu_r = r_n | r_t;
            ALU_XOR: alu_r = r_n ^ r_t;
            ALU_SHL: alu_r = big ? 16'd0 : (r_n << shamt);
            ALU_SHR: alu_r = big ? {16{r_n[15]}} : 16'($signed(r_n) >>> shamt);
            default: alu_r = '0;
        endcase
        take = 1'b0;
        case (arg)
            BR_EQ:   take = (r_b == r_n);
            BR_NE:   take = (r_b != r_n);
            BR_Z:    take = (r_n == 16'd0);
            BR_NZ:   take = (r_n != 16'd0);
            BR_N:    take = r_n[15];
            BR_P:    take = !r_n[15] && (r_n != 16'd0);
            default: take = 1'b0;
        endcase
    end

    always_comb begin
        e_status = ST_OK;
        e_sp     = r_sp;
        e_pc     = r_pc;
        e_lr     = r_lr;
        e_w1     = '0;
        e_w2     = '0;
        e_div    = 1'b0;
        case (op)
            OP_ALU: begin
                if (arg > ALU_SHR) begin
                    e_status = ST_BADFUNC;
                end else if ((arg >= ALU_NEG && arg <= ALU_NOT) ? und1 : und2) begin
                    e_status = ST_UNDER;
                end else if (arg == ALU_DIV) begin
                    if (r_t == 16'd0) begin
                        e_status = ST_DIV0;
                    end else begin
                        e_div = 1'b1;
                    end
                end else if (arg >= ALU_NEG && arg <= ALU_NOT) begin
                    e_w1 = '{we: 1'b1, addr: r_sp, wdata: alu_r};
                end else begin
                    e_w1 = '{we: 1'b1, addr: r_sp + 16'd1, wdata: alu_r};
                    e_sp = r_sp + 16'd1;
                end
            end
            OP_STACK: begin
                if (arg > SK_OVER) begin
                    e_status = ST_BADFUNC;
                end else if ((arg == SK_SWAP || arg == SK_OVER) ? und2 : und1) begin
                    e_status = ST_UNDER;
                end else if ((arg == SK_DUP || arg == SK_OVER) && r_sp == 16'd0) begin
                    e_status = ST_OVER;
                end else if (arg == SK_SWAP) begin
                    e_w1 = '{we: 1'b1, addr: r_sp, wdata: r_n};
                    e_w2 = '{we: 1'b1, addr: r_sp + 16'd1, wdata: r_t};
                end else if (arg == SK_DROP) begin
                    e_sp = r_sp + 16'd1;
                end else begin
                    e_sp = r_sp - 16'd1;
                    e_w1 = '{we: 1'b1, addr: r_sp - 16'd1,
                             wdata: (arg == SK_DUP) ? r_t : r_n};
                end
            end
            OP_BR: begin
                if (arg > BR_P) begin
                    e_status = ST_BADFUNC;
                end else if ((arg <= BR_NE) ? und3 : und2) begin
                    e_status = ST_UNDER;
                end else begin
                    e_sp = r_sp + ((arg <= BR_NE) ? 16'd3 : 16'd2);
                    if (take) begin
                        e_pc = r_pc + sext12(r_t[11:0]);
                    end
                end
            end
            OP_LDI, OP_LOAD, OP_JAL: begin
                if (r_sp == 16'd0) begin
                    e_status = ST_OVER;
                end else begin
                    e_sp = r_sp - 16'd1;
                    e_w1.we   = 1'b1;
                    e_w1.addr = r_sp - 16'd1;
                    if (op == OP_LDI) begin
                        e_w1.wdata = sarg;
                    end else if (op == OP_LOAD) begin
                        e_w1.wdata = rdata;
                    end else begin
                        e_w1.wdata = r_lr;
                        e_lr = r_pc;
                        e_pc = r_pc + sarg;
                    end
                end
            end
            OP_STW: begin
                if (und1) begin
                    e_status = ST_UNDER;
                end else begin
                    e_w1 = '{we: 1'b1, addr: r_base + sarg, wdata: r_t};
                    e_sp = r_sp + 16'd1;
                end
            end
            OP_JMP: e_pc = r_pc + sarg;
            OP_RET: begin
                if (und1) begin
                    e_status = ST_UNDER;
                end else begin
                    e_pc = r_lr;
                    e_lr = r_t;
                    e_sp = r_sp + 16'd1;
                end
            end
            OP_TRAP: begin
                if (arg >= 12'(NUM_TRAPS)) begin
                    e_status = ST_BADTRAP;
                end else if (arg == EXIT_TRAP) begin
                    e_status = ST_EXIT;
                end else begin
                    e_status = ST_TRAP;
                end
            end
            OP_HALT: e_status = ST_HALT;
            default: e_status = ST_BADOP;
        endcase
    end

    assign cfg_we = psel && penable && pwrite;

    always_comb begin
        n_state   = r_state;
        n_status  = r_status;
        n_pc      = r_pc;
        n_sp      = r_sp;
        n_lr      = r_lr;
        n_ipc     = r_ipc;
        n_base    = r_base;
        n_top     = r_top;
        n_start   = r_start;
        n_ins     = r_ins;
        n_t       = r_t;
        n_n       = r_n;
        n_b       = r_b;
        n_tos     = r_tos;
        n_code    = r_code;
        n_stopped = r_stopped;
        n_w1      = r_w1;
        n_w2      = r_w2;
        mem_req   = '{we: 1'b0, addr: r_sp, wdata: i_load_data};
        div_start = 1'b0;
        case (r_state)
            S_IDLE: begin
                mem_req.addr = i_load_addr;
                if (i_valid) begin
                    n_ipc  = r_pc;
                    n_code = '0;
                    if (!i_func) begin
                        mem_req.we = 1'b1;
                        n_status   = ST_OK;
                        n_state    = S_TOS;
                    end else if (r_stopped) begin
                        n_status = ST_STOPPED;
                        n_state  = S_TOS;
                    end else begin
                        n_state = S_FETCH;
                    end
                end
            end
            S_FETCH: begin
                mem_req.addr = r_pc;
                n_state      = S_R0;
            end
            S_R0: begin
                n_ins        = rdata;
                n_pc         = r_pc + 16'd1;
                mem_req.addr = r_sp;
                n_state      = S_R1;
            end
            S_R1: begin
                n_t          = rdata;
                mem_req.addr = r_sp + 16'd1;
                n_state      = S_R2;
            end
            S_R2: begin
                n_n          = rdata;
                mem_req.addr = r_sp + 16'd2;
                n_state      = S_R3;
            end
            S_R3: begin
                n_b          = rdata;
                mem_req.addr = r_base + sarg;
                n_state      = S_EXEC;
            end
            S_EXEC: begin
                n_status = e_status;
                n_code   = (op == OP_TRAP) ? arg : 12'd0;
                if (e_status != ST_OK && e_status != ST_TRAP) begin
                    n_stopped = 1'b1;
                end
                n_w1 = e_w1;
                n_w2 = e_w2;
                if (e_div) begin
                    div_start = 1'b1;
                    n_state   = S_DIV;
                end else begin
                    n_sp    = e_sp;
                    n_pc    = e_pc;
                    n_lr    = e_lr;
                    n_state = S_W1;
                end
            end
            S_DIV: begin
                if (div_done) begin
                    n_w1    = '{we: 1'b1, addr: r_sp + 16'd1, wdata: r_s};
                    n_w2    = '{we: 1'b1, addr: r_sp, wdata: q_s};
                    n_state = S_W1;
                end
            end
            S_W1: begin
                mem_req = r_w1;
                n_state = S_W2;
            end
            S_W2: begin
                mem_req = r_w2;
                n_state = S_TOS;
            end
            S_TOS: begin
                mem_req.addr = r_sp;
                n_state      = S_TOSC;
            end
            S_TOSC: begin
                n_tos   = (r_sp < r_top) ? rdata : 16'd0;
                n_state = S_OUT;
            end
            S_OUT: begin
                if (i_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
        if (cfg_we) begin
            case (paddr[3:2])
                REG_BASE:  n_base = pwdata[15:0];
                REG_TOP: begin
                    n_top = pwdata[15:0];
                    n_sp  = pwdata[15:0];
                end
                REG_START: begin
                    n_start = pwdata[15:0];
                    n_pc    = pwdata[15:0];
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_pc      <= START_RST;
            r_sp      <= TOP_RST;
            r_lr      <= '0;
            r_base    <= BASE_RST;
            r_top     <= TOP_RST;
            r_start   <= START_RST;
            r_stopped <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_pc      <= n_pc;
            r_sp      <= n_sp;
            r_lr      <= n_lr;
            r_base    <= n_base;
            r_top     <= n_top;
            r_start   <= n_start;
            r_stopped <= n_stopped;
        end
        r_status <= n_status;
        r_ipc    <= n_ipc;
        r_ins    <= n_ins;
        r_t      <= n_t;
        r_n      <= n_n;
        r_b      <= n_b;
        r_tos    <= n_tos;
        r_code   <= n_code;
        r_w1     <= n_w1;
        r_w2     <= n_w2;
    end

    always_comb begin
        case (paddr[3:2])
            REG_BASE:  prdata = {16'd0, r_base};
            REG_TOP:   prdata = {16'd0, r_top};
            REG_START: prdata = {16'd0, r_start};
            default:   prdata = '0;
        endcase
    end

    assign pready         = 1'b1;
    assign o_ready        = (r_state == S_IDLE);
    assign o_valid        = (r_state == S_OUT);
    assign o_status       = r_status;
    assign o_instr_pc     = r_ipc;
    assign o_next_pc      = r_pc;
    assign o_top_of_stack = r_tos;
    assign o_stack_ptr    = r_sp;
    assign o_trap_code    = r_code;

`ifndef ASSERT_OFF
    a_mem_write_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_req.we |-> (r_state == S_IDLE || r_state == S_W1 || r_state == S_W2))
        else $error("memory written outside a write slot");
    a_stop_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$fell(r_stopped))
        else $error("stop flag cleared without reset");
    a_div_exit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |=> (r_state == S_DIV || r_state == S_W1))
        else $error("division left to an unexpected state");
    a_div_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_start |-> (r_state == S_EXEC && r_t != 16'd0))
        else $error("division started with zero divisor");
`endif

endmodule

// ----- verif/tb_stack_machine_core.sv -----
// ----------------------------------------------------------------------------
// tb_stack_machine_core: self-checking testbench of the 16-bit stack CPU
// Items preload memory words and execute instructions. A predictor in the
// testbench keeps its own memory, PC, SP, link register and stop flag, and
// works out the result of every accepted item. Instructions are preloaded at
// the predicted PC just before they run. Stack words are written before they
// can be read. Several register settings are used. The machine is kept out
// of faults until the last test, which stops it once and checks the stopped
// behaviour.
// ----------------------------------------------------------------------------
module tb_stack_machine_core;
    timeunit 1ns;
    timeprecision 1ps;

    import smc_pkg::*;

    typedef struct packed {
        t_status     status;
        logic [15:0] instr_pc;
        logic [15:0] next_pc;
        logic [15:0] tos;
        logic [15:0] sp;
        logic [11:0] trap_code;
    } t_cpu_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic        i_func = 1'b0;
    logic [15:0] i_load_addr = '0;
    logic [15:0] i_load_data = '0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [3:0]  o_status;
    logic [15:0] o_instr_pc;
    logic [15:0] o_next_pc;
    logic [15:0] o_top_of_stack;
    logic [15:0] o_stack_ptr;
    logic [11:0] o_trap_code;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    stack_machine_core dut (.*);

    always #10 i_clk = ~i_clk;

    // Predicted machine state.
    logic [15:0] ram [0:65535];
    bit          ram_set [0:65535];
    logic [15:0] m_pc = START_RST;
    logic [15:0] m_sp = TOP_RST;
    logic [15:0] m_lr = '0;
    logic [15:0] m_base = BASE_RST;
    logic [15:0] m_top = TOP_RST;
    bit          m_stopped = 1'b0;

    t_cpu_result expected_results [$];
    int          n_sent = 0;
    int          n_errors = 0;
    int          burst_left = 0;
    int          stall_cnt = 0;

    function automatic void mem_write(logic [15:0] a, logic [15:0] v);
        ram[a] = v;
        ram_set[a] = 1'b1;
    endfunction

    function automatic bit stack_short(int unsigned need);
        return (int'(m_sp) + need) > int'(m_top);
    endfunction

    function automatic t_status classify_instr(logic [15:0] ins);
        logic [3:0]  op = ins[15:12];
        logic [11:0] arg = ins[11:0];
        case (op)
            OP_ALU: begin
                if (arg > ALU_SHR) return ST_BADFUNC;
                if (stack_short((arg >= ALU_NEG && arg <= ALU_NOT) ? 1 : 2)) return ST_UNDER;
                if (arg == ALU_DIV && ram[m_sp] == 16'h0) return ST_DIV0;
                return ST_OK;
            end
            OP_STACK: begin
                if (arg > SK_OVER) return ST_BADFUNC;
                if (stack_short((arg == SK_SWAP || arg == SK_OVER) ? 2 : 1)) return ST_UNDER;
                if ((arg == SK_DUP || arg == SK_OVER) && m_sp == 16'h0) return ST_OVER;
                return ST_OK;
            end
            OP_BR: begin
                if (arg > BR_P) return ST_BADFUNC;
                if (stack_short((arg <= BR_NE) ? 3 : 2)) return ST_UNDER;
                return ST_OK;
            end
            OP_LDI, OP_LOAD, OP_JAL: return (m_sp == 16'h0) ? ST_OVER : ST_OK;
            OP_STW, OP_RET: return stack_short(1) ? ST_UNDER : ST_OK;
            OP_JMP: return ST_OK;
            OP_TRAP: begin
                if (arg >= NUM_TRAPS_DEF) return ST_BADTRAP;
                return (arg == EXIT_TRAP) ? ST_EXIT : ST_TRAP;
            end
            OP_HALT: return ST_HALT;
            default: return ST_BADOP;
        endcase
    endfunction

    function automatic void apply_instr(logic [15:0] ins);
        logic [11:0] arg = ins[11:0];
        logic [15:0] imm = {{4{ins[11]}}, ins[11:0]};
        logic [15:0] t = ram[m_sp];
        logic [15:0] n = ram[m_sp + 16'd1];
        logic [15:0] b = ram[m_sp + 16'd2];
        logic [15:0] r = '0;
        int          sn = int'($signed(n));
        int          st = int'($signed(t));
        bit          take = 1'b0;
        case (ins[15:12])
            OP_ALU: begin
                if (arg == ALU_DIV) begin
                    mem_write(m_sp + 16'd1, 16'(sn % st));
                    mem_write(m_sp, 16'(sn / st));
                end else if (arg >= ALU_NEG && arg <= ALU_NOT) begin
                    case (arg)
                        ALU_NEG: r = -t;
                        ALU_INC: r = t + 16'd1;
                        ALU_DEC: r = t - 16'd1;
                        ALU_ABS: r = t[15] ? -t : t;
                        default: r = (t == 16'h0) ? 16'd1 : 16'd0;
                    endcase
                    mem_write(m_sp, r);
                end else begin
                    case (arg)
                        ALU_ADD: r = n + t;
                        ALU_SUB: r = n - t;
                        ALU_MUL: r = n * t;
                        ALU_AND: r = n & t;
                        ALU_OR:  r = n | t;
                        ALU_XOR: r = n ^ t;
                        ALU_SHL: r = (t >= 16) ? 16'h0 : (n << t);
                        default: r = (t >= 16) ? {16{n[15]}} : 16'($signed(n) >>> t);
                    endcase
                    mem_write(m_sp + 16'd1, r);
                    m_sp = m_sp + 16'd1;
                end
            end
            OP_STACK: begin
                if (arg == SK_SWAP) begin
                    mem_write(m_sp, n);
                    mem_write(m_sp + 16'd1, t);
                end else if (arg == SK_DROP) begin
                    m_sp = m_sp + 16'd1;
                end else begin
                    m_sp = m_sp - 16'd1;
                    mem_write(m_sp, (arg == SK_DUP) ? t : n);
                end
            end
            OP_BR: begin
                case (arg)
                    BR_EQ: take = (b == n);
                    BR_NE: take = (b != n);
                    BR_Z:  take = (n == 16'h0);
                    BR_NZ: take = (n != 16'h0);
                    BR_N:  take = n[15];
                    default: take = !n[15] && n != 16'h0;
                endcase
                m_sp = m_sp + ((arg <= BR_NE) ? 16'd3 : 16'd2);
                if (take) m_pc = m_pc + {{4{t[11]}}, t[11:0]};
            end
            OP_LDI: begin
                m_sp = m_sp - 16'd1;
                mem_write(m_sp, imm);
            end
            OP_LOAD: begin
                r = ram[m_base + imm];
                m_sp = m_sp - 16'd1;
                mem_write(m_sp, r);
            end
            OP_JAL: begin
                m_sp = m_sp - 16'd1;
                mem_write(m_sp, m_lr);
                m_lr = m_pc;
                m_pc = m_pc + imm;
            end
            OP_STW: begin
                mem_write(m_base + imm, t);
                m_sp = m_sp + 16'd1;
            end
            OP_JMP: m_pc = m_pc + imm;
            OP_RET: begin
                m_pc = m_lr;
                m_lr = t;
                m_sp = m_sp + 16'd1;
            end
            default: ;
        endcase
    endfunction

    function automatic t_cpu_result cpu_step(bit f, logic [15:0] a, logic [15:0] d);
        t_cpu_result res;
        logic [15:0] ins;
        res.status = ST_OK;
        res.instr_pc = m_pc;
        res.trap_code = '0;
        if (!f) begin
            mem_write(a, d);
        end else if (m_stopped) begin
            res.status = ST_STOPPED;
        end else begin
            ins = ram[m_pc];
            m_pc = m_pc + 16'd1;
            res.status = classify_instr(ins);
            if (ins[15:12] == OP_TRAP) res.trap_code = ins[11:0];
            if (res.status == ST_OK || res.status == ST_TRAP) apply_instr(ins);
            else m_stopped = 1'b1;
        end
        res.next_pc = m_pc;
        res.sp = m_sp;
        res.tos = (m_sp < m_top) ? ram[m_sp] : 16'h0;
        return res;
    endfunction

    // Receiver: rotates through four ready patterns: always ready, random, sparse and mostly ready.
    always @(posedge i_clk) begin
        stall_cnt <= stall_cnt + 1;
        case ((stall_cnt >> 6) % 4)
            0: i_ready <= 1'b1;
            1: i_ready <= ($urandom_range(0, 1) == 1);
            2: i_ready <= (stall_cnt % 4 == 0);
            default: i_ready <= ($urandom_range(0, 4) != 0);
        endcase
    end

    always @(posedge i_clk) begin
        t_cpu_result want;
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_results.size() == 0) begin
                n_errors++;
                if (n_errors <= 10) $display("Unexpected result item, status %0d", o_status);
            end else begin
                want = expected_results.pop_front();
                if (o_status !== want.status || o_instr_pc !== want.instr_pc
                        || o_next_pc !== want.next_pc || o_top_of_stack !== want.tos
                        || o_stack_ptr !== want.sp || o_trap_code !== want.trap_code) begin
                    n_errors++;
                    if (n_errors <= 10) begin
                        $display("Mismatch: exp st=%0d ipc=%h npc=%h tos=%h sp=%h trap=%h",
                            want.status, want.instr_pc, want.next_pc, want.tos, want.sp,
                            want.trap_code);
                        $display("          got st=%0d ipc=%h npc=%h tos=%h sp=%h trap=%h",
                            o_status, o_instr_pc, o_next_pc, o_top_of_stack, o_stack_ptr,
                            o_trap_code);
                    end
                end
            end
        end
    end

    task automatic send_item(bit f, logic [15:0] a, logic [15:0] d);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            burst_left = $urandom_range(1, 12);
            if (gap > 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        i_valid <= 1'b1;
        i_func <= f;
        i_load_addr <= a;
        i_load_data <= d;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        expected_results.push_back(cpu_step(f, a, d));
        n_sent++;
    endtask

    task automatic settle();
        i_valid <= 1'b0;
        burst_left = 0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [15:0] v);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= {16'h0, v};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_BASE: m_base = v;
            REG_TOP: begin
                m_top = v;
                m_sp = v;
            end
            default: m_pc = v;
        endcase
    endtask

    task automatic set_config(logic [15:0] base, logic [15:0] top, logic [15:0] pc);
        settle();
        write_reg(REG_BASE, base);
        write_reg(REG_TOP, top);
        write_reg(REG_START, pc);
    endtask

    function automatic logic [15:0] rand_word();
        case ($urandom_range(0, 7))
            0: return 16'h0000;
            1: return 16'hFFFF;
            2: return 16'h8000;
            3: return 16'h7FFF;
            4: return 16'($urandom_range(0, 20));
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic fill_word(logic [15:0] a);
        if (!ram_set[a]) send_item(1'b0, a, rand_word());
    endtask

    task automatic fill_stack();
        for (int k = 0; k < 4; k++) fill_word(m_sp + 16'(k));
    endtask

    function automatic t_status outcome_at_pc(logic [15:0] ins);
        logic [15:0] keep = ram[m_pc];
        t_status     st;
        ram[m_pc] = ins;
        st = classify_instr(ins);
        ram[m_pc] = keep;
        return st;
    endfunction

    function automatic bit runs_on(logic [15:0] ins);
        t_status st = outcome_at_pc(ins);
        return st == ST_OK || st == ST_TRAP;
    endfunction

    task automatic run_instr(logic [15:0] ins);
        if (ins[15:12] == OP_LOAD) fill_word(m_base + {{4{ins[11]}}, ins[11:0]});
        send_item(1'b0, m_pc, ins);
        send_item(1'b1, 16'($urandom), 16'($urandom));
    endtask

    function automatic logic [15:0] random_instr();
        int          k = $urandom_range(0, 99);
        logic [11:0] arg = 12'($urandom);
        if (int'(m_top) - int'(m_sp) < 3 && $urandom_range(0, 1) == 1) k = 70;
        if (k < 35) return {OP_ALU, 12'($urandom_range(0, 13))};
        if (k < 50) return {OP_STACK, 12'($urandom_range(0, 3))};
        if (k < 60) return {OP_BR, 12'($urandom_range(0, 5))};
        if (k < 75) return {OP_LDI, arg};
        if (k < 82) return {OP_LOAD, arg};
        if (k < 88) return {OP_STW, arg};
        if (k < 91) return {OP_JMP, arg};
        if (k < 94) return {OP_JAL, arg};
        if (k < 97) return {OP_RET, arg};
        arg = 12'($urandom_range(0, 4));
        return {OP_TRAP, (arg == EXIT_TRAP) ? 12'd4 : arg};
    endfunction

    task automatic run_random_instr();
        logic [15:0] ins;
        fill_stack();
        ins = {OP_JMP, 12'($urandom)};
        for (int k = 0; k < 32; k++) begin
            ins = random_instr();
            if (runs_on(ins)) break;
            ins = {OP_JMP, 12'($urandom)};
        end
        run_instr(ins);
    endtask

    task automatic test_directed();
        logic [15:0] prog [$];
        prog = '{{OP_LDI, 12'h7FF}, {OP_LDI, 12'h800}, {OP_ALU, ALU_ADD},
                 {OP_LDI, 12'h005}, {OP_ALU, ALU_MUL}, {OP_LDI, 12'hFFD},
                 {OP_ALU, ALU_DIV}, {OP_ALU, ALU_NEG}, {OP_ALU, ALU_INC},
                 {OP_ALU, ALU_DEC}, {OP_ALU, ALU_ABS}, {OP_ALU, ALU_NOT},
                 {OP_LDI, 12'h800}, {OP_LDI, 12'h010}, {OP_ALU, ALU_SHR},
                 {OP_LDI, 12'h00F}, {OP_ALU, ALU_SHL}, {OP_LDI, 12'h0F0},
                 {OP_ALU, ALU_AND}, {OP_LDI, 12'h00F}, {OP_ALU, ALU_OR},
                 {OP_LDI, 12'hFFF}, {OP_ALU, ALU_XOR}, {OP_ALU, ALU_SUB},
                 {OP_STACK, SK_SWAP}, {OP_STACK, SK_DUP}, {OP_STACK, SK_OVER},
                 {OP_STACK, SK_DROP}, {OP_LDI, 12'h003}, {OP_BR, BR_EQ},
                 {OP_LDI, 12'h002}, {OP_LDI, 12'h003}, {OP_BR, BR_NE},
                 {OP_LDI, 12'h000}, {OP_LDI, 12'h002}, {OP_BR, BR_Z},
                 {OP_LDI, 12'h001}, {OP_LDI, 12'hFFE}, {OP_BR, BR_NZ},
                 {OP_LDI, 12'h800}, {OP_LDI, 12'h002}, {OP_BR, BR_N},
                 {OP_LDI, 12'h7FF}, {OP_LDI, 12'h002}, {OP_BR, BR_P},
                 {OP_LDI, 12'h123}, {OP_STW, 12'h005}, {OP_LOAD, 12'h005},
                 {OP_JAL, 12'h002}, {OP_RET, 12'h000}, {OP_JMP, 12'hFFE},
                 {OP_TRAP, 12'd0}, {OP_TRAP, 12'd1}, {OP_TRAP, 12'd3},
                 {OP_TRAP, 12'd4}};
        send_item(1'b0, 16'h0000, 16'hFFFF);
        send_item(1'b0, 16'hFFFF, 16'h0000);
        foreach (prog[k]) begin
            fill_stack();
            if (runs_on(prog[k])) run_instr(prog[k]);
        end
    endtask

    task automatic test_random(int count, bit pause_midway);
        int stop_at = n_sent + count;
        int pause_at = n_sent + count / 2;
        while (n_sent < stop_at) begin
            if (pause_midway && n_sent >= pause_at) begin
                settle();
                pause_midway = 1'b0;
            end
            if ($urandom_range(0, 9) == 0) send_item(1'b0, 16'($urandom), 16'($urandom));
            else run_random_instr();
        end
    endtask

    // Stops the machine once, then checks that executes do nothing.
    task automatic test_stop();
        logic [15:0] ins;
        fill_stack();
        ins = {OP_HALT, 12'h000};
        for (int k = 0; k < 200; k++) begin
            ins = 16'($urandom);
            if (!runs_on(ins)) break;
            ins = {OP_HALT, 12'h000};
        end
        run_instr(ins);
        for (int k = 0; k < 6; k++) begin
            if (k % 2 == 0) send_item(1'b0, 16'($urandom), 16'($urandom));
            send_item(1'b1, 16'($urandom), 16'($urandom));
        end
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        set_config(16'h0000, 16'hFFFF, 16'h0000);
        test_random(250, 1'b0);
        set_config(16'hFFFF, 16'h0004, 16'hFFFF);
        test_random(200, 1'b0);
        set_config(16'($urandom), 16'h0000, 16'($urandom));
        test_random(60, 1'b0);
        set_config(16'($urandom), 16'h8000 + 16'($urandom_range(0, 32767)), 16'($urandom));
        test_random(400, 1'b1);
        test_stop();
        settle();
        if (n_errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    initial begin
        #20000000;
        $display("TEST FAILED");
        $finish;
    end

endmodule

// ----- stack_machine_core.f -----
src/smc_pkg.sv
src/smc_mem.sv
src/smc_div.sv
src/stack_machine_core.sv
verif/tb_stack_machine_core.sv
